/* hdl/srsw_pkg.sv */
// Shared constants for the selective-repeat sender window.
// Event codes, configuration register indexes, reset values and field widths.
// No dependencies.
package srsw_pkg;

  localparam int SEQ_BITS_DEF     = 3;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int OP_W      = 2;
  localparam int FIELD_W   = 3;
  localparam int WIN_W     = 3;
  localparam int CNT_CFG_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_COUNT = 1'd1;

  localparam logic [WIN_W-1:0]     WIN_LIMIT_RST = 3'd4;
  localparam logic [CNT_CFG_W-1:0] SEQ_COUNT_RST = 4'd8;

endpackage

/* hdl/srsw_mod_unit.sv */
// Shared restoring remainder unit: x % m, one quotient bit per cycle.
// Used by the sender window sequencer for its base, next-sequence and in-flight reductions.
// No package dependencies.
module srsw_mod_unit #(
  parameter int W = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] m,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  rem_r;
  logic [W:0]    sh;
  logic [W:0]    diff;
  logic [W-1:0]  rem_nxt;

  always_comb begin
    sh   = {rem_r, x_r[W-1]};
    diff = sh - {1'b0, m};
    if (sh >= {1'b0, m}) begin
      rem_nxt = diff[W-1:0];
    end else begin
      rem_nxt = sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      x_r   <= x_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hdl/selective_repeat_sender_window.sv */
// Selective-repeat ARQ sender window. One item (send, acknowledgement, timeout) is taken at a
// time and in_tready stays low until its result item has been taken. The base, next-sequence
// and in-flight reductions run through one shared restoring remainder unit; the acknowledgement
// offset is reduced by a compare and subtract. An accepted send adds a reduction of the next
// sequence number, and an accepted acknowledgement adds one reduction for each entry the base
// steps past. A stalled result holds the item until it is taken.
// Depends on srsw_pkg and srsw_mod_unit.
module selective_repeat_sender_window #(
  parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF,
  parameter int PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS_DEF,
  localparam int IN_W  = ((PAYLOAD_BITS + 3 * srsw_pkg::FIELD_W + 1 + 7) / 8) * 8,
  localparam int OUT_W = ((PAYLOAD_BITS + 5 * srsw_pkg::FIELD_W + 5 + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // cfg_data: send window limit [2:0] or seq_count [3:0]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: payload, ack_num, ack_corrupt, timeout_seq, zero pad
  input  logic [IN_W-1:0]                     in_tdata,
  // in_tuser: op
  input  logic [srsw_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: accepted, tx_valid, tx_seq, tx_payload, timer_start, timer_stop,
  // timer_seq, window_base, next_seq, window_full, zero pad
  output logic [OUT_W-1:0]                    out_tdata
);

  localparam int DEPTH = 1 << SEQ_BITS;
  localparam int MW    = SEQ_BITS + 1;
  localparam int CW    = (MW > srsw_pkg::CNT_CFG_W) ? MW : srsw_pkg::CNT_CFG_W;
  localparam int FW    = srsw_pkg::FIELD_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PRE_BM   = 4'd1;
  localparam logic [3:0] S_PRE_CNT  = 4'd2;
  localparam logic [3:0] S_DISPATCH = 4'd3;
  localparam logic [3:0] S_SEND_NX  = 4'd4;
  localparam logic [3:0] S_ADV_CHK  = 4'd5;
  localparam logic [3:0] S_ADV_MOD  = 4'd6;
  localparam logic [3:0] S_POST_BM  = 4'd7;
  localparam logic [3:0] S_POST_CNT = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  // configuration
  logic [srsw_pkg::WIN_W-1:0]     win_cfg_r;
  logic [srsw_pkg::CNT_CFG_W-1:0] cnt_cfg_r;
  logic [CW-1:0]                  m_c;
  logic [CW-1:0]                  w_c;
  logic [MW-1:0]                  m;
  logic [MW-1:0]                  w;

  // latched item
  logic [srsw_pkg::OP_W-1:0]      op_r;
  logic [PAYLOAD_BITS-1:0]        pay_r;
  logic [SEQ_BITS-1:0]            ack_r;
  logic                           corrupt_r;
  logic [SEQ_BITS-1:0]            tseq_r;

  // window state
  logic [3:0]                     state_r, state_nxt;
  logic [SEQ_BITS-1:0]            base_r, base_nxt;
  logic [SEQ_BITS-1:0]            next_r, next_nxt;
  logic [MW-1:0]                  bm_r, bm_nxt;
  logic [MW-1:0]                  cnt_r, cnt_nxt;
  logic [MW-1:0]                  iter_r, iter_nxt;
  logic [DEPTH-1:0]               acked_r;
  logic [PAYLOAD_BITS-1:0]        mem [DEPTH];
  logic [PAYLOAD_BITS-1:0]        rd_r;

  // result
  logic                           res_acc_r, res_acc_nxt;
  logic                           res_txv_r, res_txv_nxt;
  logic [SEQ_BITS-1:0]            res_txs_r, res_txs_nxt;
  logic [PAYLOAD_BITS-1:0]        res_txp_r, res_txp_nxt;
  logic                           res_tst_r, res_tst_nxt;
  logic                           res_tsp_r, res_tsp_nxt;
  logic [SEQ_BITS-1:0]            res_tms_r, res_tms_nxt;
  logic                           res_full_r, res_full_nxt;

  // shared unit and control
  logic                           mu_start;
  logic [MW-1:0]                  mu_x;
  logic                           mu_busy;
  logic                           mu_done;
  logic [MW-1:0]                  mu_rem;
  logic [MW:0]                    cnt_sum;
  logic [MW:0]                    d_sum;
  logic [MW:0]                    d_red;
  logic                           ack_ok;
  logic                           mem_we;
  logic                           mark_set;
  logic                           mark_clr;
  logic                           in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (CW'(cnt_cfg_r) < CW'(2)) begin
      m_c = CW'(2);
    end else if (CW'(cnt_cfg_r) > CW'(DEPTH)) begin
      m_c = CW'(DEPTH);
    end else begin
      m_c = CW'(cnt_cfg_r);
    end
    if (win_cfg_r == '0) begin
      w_c = CW'(1);
    end else begin
      w_c = CW'(win_cfg_r);
    end
    if (w_c > m_c - CW'(1)) begin
      w_c = m_c - CW'(1);
    end
    m = m_c[MW-1:0];
    w = w_c[MW-1:0];
  end

  always_comb begin
    cnt_sum = (MW+1)'(next_r) + (MW+1)'(m) - (MW+1)'(mu_rem);
    d_sum   = (MW+1)'(ack_r) + (MW+1)'(m) - (MW+1)'(bm_r);
    if (d_sum >= (MW+1)'(m)) begin
      d_red = d_sum - (MW+1)'(m);
    end else begin
      d_red = d_sum;
    end
    ack_ok = !corrupt_r && ((MW+1)'(ack_r) < (MW+1)'(m)) && (d_red < (MW+1)'(cnt_r));
  end

  srsw_mod_unit #(
    .W(MW)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mu_start),
    .x    (mu_x),
    .m    (m),
    .busy (mu_busy),
    .done (mu_done),
    .rem  (mu_rem)
  );

  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    next_nxt     = next_r;
    bm_nxt       = bm_r;
    cnt_nxt      = cnt_r;
    iter_nxt     = iter_r;
    res_acc_nxt  = res_acc_r;
    res_txv_nxt  = res_txv_r;
    res_txs_nxt  = res_txs_r;
    res_txp_nxt  = res_txp_r;
    res_tst_nxt  = res_tst_r;
    res_tsp_nxt  = res_tsp_r;
    res_tms_nxt  = res_tms_r;
    res_full_nxt = res_full_r;
    mu_start     = 1'b0;
    mu_x         = '0;
    mem_we       = 1'b0;
    mark_set     = 1'b0;
    mark_clr     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_acc_nxt = 1'b0;
          res_txv_nxt = 1'b0;
          res_txs_nxt = '0;
          res_txp_nxt = '0;
          res_tst_nxt = 1'b0;
          res_tsp_nxt = 1'b0;
          res_tms_nxt = '0;
          mu_start    = 1'b1;
          mu_x        = MW'(base_r);
          state_nxt   = S_PRE_BM;
        end
      end
      S_PRE_BM: begin
        if (mu_done) begin
          bm_nxt    = mu_rem;
          mu_start  = 1'b1;
          mu_x      = cnt_sum[MW-1:0];
          state_nxt = S_PRE_CNT;
        end
      end
      S_PRE_CNT: begin
        if (mu_done) begin
          cnt_nxt   = mu_rem;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        mu_start  = 1'b1;
        mu_x      = MW'(base_r);
        state_nxt = S_POST_BM;
        case (op_r)
          srsw_pkg::OP_SEND: begin
            if (cnt_r < w) begin
              mem_we      = 1'b1;
              mark_clr    = 1'b1;
              res_acc_nxt = 1'b1;
              res_txv_nxt = 1'b1;
              res_txs_nxt = next_r;
              res_txp_nxt = pay_r;
              res_tst_nxt = 1'b1;
              res_tms_nxt = next_r;
              mu_x        = MW'(next_r) + MW'(1);
              state_nxt   = S_SEND_NX;
            end
          end
          srsw_pkg::OP_ACK: begin
            if (ack_ok) begin
              mark_set    = 1'b1;
              res_acc_nxt = 1'b1;
              res_tsp_nxt = 1'b1;
              res_tms_nxt = ack_r;
              iter_nxt    = '0;
              mu_start    = 1'b0;
              state_nxt   = S_ADV_CHK;
            end
          end
          srsw_pkg::OP_TIMEOUT: begin
            res_txv_nxt = 1'b1;
            res_txs_nxt = tseq_r;
            res_txp_nxt = rd_r;
            res_tst_nxt = 1'b1;
            res_tsp_nxt = 1'b1;
            res_tms_nxt = tseq_r;
          end
          default: begin
          end
        endcase
      end
      S_SEND_NX: begin
        if (mu_done) begin
          next_nxt  = mu_rem[SEQ_BITS-1:0];
          mu_start  = 1'b1;
          mu_x      = MW'(base_r);
          state_nxt = S_POST_BM;
        end
      end
      S_ADV_CHK: begin
        mu_start = 1'b1;
        if (iter_r == MW'(DEPTH) || base_r == next_r || !acked_r[base_r]) begin
          mu_x      = MW'(base_r);
          state_nxt = S_POST_BM;
        end else begin
          mu_x      = MW'(base_r) + MW'(1);
          state_nxt = S_ADV_MOD;
        end
      end
      S_ADV_MOD: begin
        if (mu_done) begin
          base_nxt  = mu_rem[SEQ_BITS-1:0];
          iter_nxt  = iter_r + MW'(1);
          state_nxt = S_ADV_CHK;
        end
      end
      S_POST_BM: begin
        if (mu_done) begin
          mu_start  = 1'b1;
          mu_x      = cnt_sum[MW-1:0];
          state_nxt = S_POST_CNT;
        end
      end
      S_POST_CNT: begin
        if (mu_done) begin
          res_full_nxt = (mu_rem >= w);
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      base_r     <= '0;
      next_r     <= '0;
      iter_r     <= '0;
      res_full_r <= 1'b0;
      acked_r    <= '0;
      win_cfg_r  <= srsw_pkg::WIN_LIMIT_RST;
      cnt_cfg_r  <= srsw_pkg::SEQ_COUNT_RST;
    end else begin
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      next_r     <= next_nxt;
      iter_r     <= iter_nxt;
      res_full_r <= res_full_nxt;
      if (mark_clr) begin
        acked_r[next_r] <= 1'b0;
      end
      if (mark_set) begin
        acked_r[ack_r] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srsw_pkg::CFG_WIN_LIMIT: win_cfg_r <= cfg_data[srsw_pkg::WIN_W-1:0];
          srsw_pkg::CFG_SEQ_COUNT: cnt_cfg_r <= cfg_data[srsw_pkg::CNT_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_tuser;
      pay_r     <= in_tdata[PAYLOAD_BITS-1:0];
      ack_r     <= SEQ_BITS'(in_tdata[PAYLOAD_BITS +: FW]);
      corrupt_r <= in_tdata[PAYLOAD_BITS + FW];
      tseq_r    <= SEQ_BITS'(in_tdata[PAYLOAD_BITS + FW + 1 +: FW]);
    end
    bm_r      <= bm_nxt;
    cnt_r     <= cnt_nxt;
    res_acc_r <= res_acc_nxt;
    res_txv_r <= res_txv_nxt;
    res_txs_r <= res_txs_nxt;
    res_txp_r <= res_txp_nxt;
    res_tst_r <= res_tst_nxt;
    res_tsp_r <= res_tsp_nxt;
    res_tms_r <= res_tms_nxt;
  end

  // packet store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[next_r] <= pay_r;
    end
    rd_r <= mem[tseq_r];
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = OUT_W'({res_full_r, FW'(next_r), FW'(base_r), FW'(res_tms_r),
                              res_tsp_r, res_tst_r, res_txp_r, FW'(res_txs_r),
                              res_txv_r, res_acc_r});

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_unit_started: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> mu_busy)
    else $error("remainder unit not started on an accepted item");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV_CHK) |-> (iter_r <= MW'(DEPTH)))
    else $error("base advance ran past the store depth");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_POST_CNT))
    else $error("result raised before the window count finished");

endmodule

/* bench/selective_repeat_sender_window_tb.sv */
// Testbench for selective_repeat_sender_window: directed and random send, ack and timeout
// items checked field by field against a predictor of the ARQ window kept in this file.
// Depends on srsw_pkg and the selective_repeat_sender_window RTL.
`timescale 1ns / 100ps

module selective_repeat_sender_window_tb;

  localparam int DEPTH      = 1 << srsw_pkg::SEQ_BITS_DEF;
  localparam int SEQ_MASK   = DEPTH - 1;
  localparam int PB         = srsw_pkg::PAYLOAD_BITS_DEF;
  localparam int FW         = srsw_pkg::FIELD_W;
  localparam int IN_W       = ((PB + 3 * FW + 1 + 7) / 8) * 8;
  localparam int OUT_W      = ((PB + 5 * FW + 5 + 7) / 8) * 8;
  localparam int LIMIT      = 1000000;
  localparam int CFG_SETTLE = 10;
  localparam int END_SETTLE = 100;
  localparam int PHASE_ITEMS = 118;
  localparam logic [srsw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [srsw_pkg::OP_W-1:0]   op;
    logic [FW-1:0]               timeout_seq;
    logic                        ack_corrupt;
    logic [FW-1:0]               ack_num;
    logic [PB-1:0]               payload;
  } arq_event_t;

  // same bit order as out_tdata, accepted in bit 0
  typedef struct packed {
    logic                        window_full;
    logic [FW-1:0]               next_seq;
    logic [FW-1:0]               window_base;
    logic [FW-1:0]               timer_seq;
    logic                        timer_stop;
    logic                        timer_start;
    logic [PB-1:0]               tx_payload;
    logic [FW-1:0]               tx_seq;
    logic                        tx_valid;
    logic                        accepted;
  } window_report_t;

  logic                                clk;
  logic                                rst_n      = 1'b0;
  logic                                cfg_valid  = 1'b0;
  logic                                cfg_ready;
  logic [srsw_pkg::CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_data   = '0;
  logic                                in_tvalid  = 1'b0;
  logic                                in_tready;
  logic [IN_W-1:0]                     in_tdata   = '0;
  logic [srsw_pkg::OP_W-1:0]           in_tuser   = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [OUT_W-1:0]                    out_tdata;

  selective_repeat_sender_window dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predicted window state
  logic [PB-1:0]                       pkt_mem [DEPTH];
  bit                                  acked   [DEPTH];
  bit                                  written [DEPTH];
  int                                  base_pos;
  int                                  next_pos;
  logic [srsw_pkg::WIN_W-1:0]          win_reg   = srsw_pkg::WIN_LIMIT_RST;
  logic [srsw_pkg::CNT_CFG_W-1:0]      count_reg = srsw_pkg::SEQ_COUNT_RST;

  window_report_t pending_reports [$];
  int errors     = 0;
  int cycles     = 0;
  int burst_left = 1;
  bit steady     = 1'b0;
  int hold_req   = 0;
  int hold_left  = 0;
  int rx_mode    = 0;
  int mode_left  = 0;
  window_report_t seen;
  window_report_t want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("selective_repeat_sender_window_tb: FAIL");
      $finish;
    end
  end

  function automatic int seq_mod();
    int m = count_reg;
    if (m < 2) m = 2;
    if (m > DEPTH) m = DEPTH;
    return m;
  endfunction

  function automatic int win_eff(int m);
    int w = win_reg;
    if (w < 1) w = 1;
    if (w > m - 1) w = m - 1;
    return w;
  endfunction

  function automatic int in_flight(int m);
    return ((next_pos & SEQ_MASK) + m - ((base_pos & SEQ_MASK) % m)) % m;
  endfunction

  function automatic window_report_t window_step(arq_event_t ev);
    window_report_t r;
    int m, w, cnt, s, b, ack, i;
    r = '0;
    m = seq_mod();
    w = win_eff(m);
    ack = ev.ack_num;
    case (ev.op)
      srsw_pkg::OP_SEND: begin
        if (in_flight(m) < w) begin
          s = next_pos & SEQ_MASK;
          pkt_mem[s] = ev.payload;
          acked[s] = 1'b0;
          written[s] = 1'b1;
          r.accepted = 1'b1;
          r.tx_valid = 1'b1;
          r.tx_seq = FW'(s);
          r.tx_payload = ev.payload;
          r.timer_start = 1'b1;
          r.timer_seq = FW'(s);
          next_pos = (s + 1) % m;
        end
      end
      srsw_pkg::OP_ACK: begin
        cnt = in_flight(m);
        b = base_pos & SEQ_MASK;
        if (!ev.ack_corrupt && ack < m && ((ack + m - (b % m)) % m) < cnt) begin
          r.accepted = 1'b1;
          r.timer_stop = 1'b1;
          r.timer_seq = FW'(ack);
          acked[ack] = 1'b1;
          b = base_pos;
          for (i = 0; i < DEPTH && b != next_pos && acked[b]; i++) begin
            base_pos = (b + 1) % m;
            b = base_pos;
          end
        end
      end
      srsw_pkg::OP_TIMEOUT: begin
        r.tx_valid = 1'b1;
        r.tx_seq = ev.timeout_seq;
        r.tx_payload = pkt_mem[ev.timeout_seq];
        r.timer_start = 1'b1;
        r.timer_stop = 1'b1;
        r.timer_seq = ev.timeout_seq;
      end
      default: ;
    endcase
    r.window_base = FW'(base_pos);
    r.next_seq = FW'(next_pos);
    r.window_full = in_flight(m) >= w;
    return r;
  endfunction

  function automatic logic [PB-1:0] rand_payload();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic arq_event_t make_event(logic [srsw_pkg::OP_W-1:0] op,
                                            logic [PB-1:0] payload,
                                            int ack, bit corrupt, int tseq);
    arq_event_t ev;
    ev.op = op;
    ev.payload = payload;
    ev.ack_num = FW'(ack);
    ev.ack_corrupt = corrupt;
    ev.timeout_seq = FW'(tseq);
    return ev;
  endfunction

  // mostly well-formed traffic: sends, in-window acks, timeouts of stored packets
  function automatic arq_event_t gen_event();
    arq_event_t ev;
    int m, cnt, roll, k, s;
    int stored [$];
    ev = make_event(srsw_pkg::OP_SEND, rand_payload(), $urandom_range(0, 7),
                    1'($urandom_range(0, 1)), $urandom_range(0, 7));
    m = seq_mod();
    cnt = in_flight(m);
    roll = $urandom_range(0, 99);
    if (roll >= 42 && roll < 80) begin
      if (cnt > 0) begin
        k = $urandom_range(0, 1) ? 0 : $urandom_range(0, cnt - 1);
        ev.op = srsw_pkg::OP_ACK;
        ev.ack_num = FW'(((base_pos % m) + k) % m);
        ev.ack_corrupt = 1'b0;
      end
    end else if (roll >= 80 && roll < 93) begin
      for (s = 0; s < DEPTH; s++)
        if (written[s]) stored.push_back(s);
      if (stored.size() > 0) begin
        ev.op = srsw_pkg::OP_TIMEOUT;
        ev.timeout_seq = FW'(stored[$urandom_range(0, stored.size() - 1)]);
      end
    end else if (roll >= 93) begin
      case ($urandom_range(0, 2))
        0: ev.op = OP_UNUSED;
        1: ev.op = srsw_pkg::OP_ACK;
        default: begin
          ev.op = srsw_pkg::OP_ACK;
          ev.ack_corrupt = 1'b1;
        end
      endcase
    end
    return ev;
  endfunction

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  // result side: own stall pattern, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[$bits(window_report_t)-1:0];
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, actual %0h", $time, seen);
      end else begin
        want = pending_reports.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(seen.accepted));
        check_field("tx_valid", 64'(want.tx_valid), 64'(seen.tx_valid));
        check_field("tx_seq", 64'(want.tx_seq), 64'(seen.tx_seq));
        check_field("tx_payload", 64'(want.tx_payload), 64'(seen.tx_payload));
        check_field("timer_start", 64'(want.timer_start), 64'(seen.timer_start));
        check_field("timer_stop", 64'(want.timer_stop), 64'(seen.timer_stop));
        check_field("timer_seq", 64'(want.timer_seq), 64'(seen.timer_seq));
        check_field("window_base", 64'(want.window_base), 64'(seen.window_base));
        check_field("next_seq", 64'(want.next_seq), 64'(seen.next_seq));
        check_field("window_full", 64'(want.window_full), 64'(seen.window_full));
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic post(input arq_event_t ev);
    window_report_t rep;
    int gap;
    in_tdata <= IN_W'({ev.timeout_seq, ev.ack_corrupt, ev.ack_num, ev.payload});
    in_tuser <= ev.op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    rep = window_step(ev);
    pending_reports.push_back(rep);
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic drain(input int settle);
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [srsw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srsw_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == srsw_pkg::CFG_WIN_LIMIT) win_reg = val[srsw_pkg::WIN_W-1:0];
    else count_reg = val;
    @(posedge clk);
  endtask

  // walk the window back to base = next = 0 so a new modulus keeps positions in range
  task automatic rewind_window();
    arq_event_t ev;
    int m, guard;
    guard = 0;
    while ((base_pos != 0 || next_pos != 0) && guard < 64) begin
      m = seq_mod();
      ev = make_event(srsw_pkg::OP_SEND, rand_payload(), 0, 1'b0, $urandom_range(0, 7));
      if (in_flight(m) > 0) begin
        ev.op = srsw_pkg::OP_ACK;
        ev.ack_num = FW'(base_pos % m);
      end
      post(ev);
      guard++;
    end
  endtask

  task automatic test_directed_basic();
    post(make_event(srsw_pkg::OP_SEND, 64'h0, 0, 1'b0, 0));
    post(make_event(srsw_pkg::OP_SEND, '1, 7, 1'b1, 7));
    post(make_event(srsw_pkg::OP_SEND, 64'h5555_5555_5555_5555, 0, 1'b0, 0));
    post(make_event(srsw_pkg::OP_SEND, 64'haaaa_aaaa_aaaa_aaaa, 0, 1'b0, 0));
    post(make_event(srsw_pkg::OP_SEND, 64'h0123_4567_89ab_cdef, 0, 1'b0, 0));   // full
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 2, 1'b1, 0));                      // corrupt
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 5, 1'b0, 0));                      // outside
    post(make_event(srsw_pkg::OP_ACK, '1, 7, 1'b1, 7));
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 1, 1'b0, 0));                      // out of order
    post(make_event(srsw_pkg::OP_TIMEOUT, 64'h0, 0, 1'b0, 3));
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 0, 1'b0, 0));                      // base jumps
    post(make_event(OP_UNUSED, '1, 7, 1'b1, 7));
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 2, 1'b0, 0));
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 3, 1'b0, 0));
  endtask

  task automatic test_directed_config();
    drain(CFG_SETTLE);
    write_reg(srsw_pkg::CFG_WIN_LIMIT, 4'd0);                         // acts as 1
    write_reg(srsw_pkg::CFG_SEQ_COUNT, 4'd5);
    post(make_event(srsw_pkg::OP_SEND, rand_payload(), 0, 1'b0, 0));
    post(make_event(srsw_pkg::OP_SEND, rand_payload(), 0, 1'b0, 0));
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 4, 1'b0, 0));
    drain(CFG_SETTLE);
    write_reg(srsw_pkg::CFG_SEQ_COUNT, 4'd0);                         // modulus saturates to 2
    write_reg(srsw_pkg::CFG_WIN_LIMIT, 4'd7);                         // window saturates to 1
    post(make_event(srsw_pkg::OP_SEND, rand_payload(), 0, 1'b0, 0));
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 3, 1'b0, 0));            // not below modulus
    post(make_event(srsw_pkg::OP_ACK, 64'h0, 0, 1'b0, 0));
    post(make_event(srsw_pkg::OP_TIMEOUT, 64'h0, 0, 1'b0, 3));        // stale stored packet
  endtask

  task automatic test_random_phases();
    int wins [10];
    int cnts [10];
    int p, done;
    wins = '{4, 1, 7, 2, 0, 3, 4, 5, 0, 0};
    cnts = '{8, 2, 15, 3, 1, 8, 6, 12, 0, 0};
    for (p = 8; p < 10; p++) begin
      wins[p] = $urandom_range(0, 7);
      cnts[p] = $urandom_range(0, 15);
    end
    for (p = 0; p < 10; p++) begin
      rewind_window();
      drain(CFG_SETTLE);
      write_reg(srsw_pkg::CFG_WIN_LIMIT, srsw_pkg::CFG_DATA_W'(wins[p]));
      write_reg(srsw_pkg::CFG_SEQ_COUNT, srsw_pkg::CFG_DATA_W'(cnts[p]));
      steady = (p % 4 == 3);
      for (done = 0; done < PHASE_ITEMS; done++) post(gen_event());
      steady = 1'b0;
    end
  endtask

  // result side holds off while items keep coming, then the sender waits for every result
  task automatic test_backpressure();
    int n;
    drain(CFG_SETTLE);
    hold_req = 400;
    steady = 1'b1;
    for (n = 0; n < 24; n++) post(gen_event());
    steady = 1'b0;
    drain(CFG_SETTLE);
    for (n = 0; n < 16; n++) post(gen_event());
  endtask

  initial begin
    base_pos = 0;
    next_pos = 0;
    for (int s = 0; s < DEPTH; s++) begin
      pkt_mem[s] = '0;
      acked[s] = 1'b0;
      written[s] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basic();
    test_directed_config();
    test_random_phases();
    test_backpressure();
    drain(END_SETTLE);
    if (errors == 0) $display("selective_repeat_sender_window_tb: PASS");
    else $display("selective_repeat_sender_window_tb: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/srsw_pkg.sv
hdl/srsw_mod_unit.sv
hdl/selective_repeat_sender_window.sv
bench/selective_repeat_sender_window_tb.sv
